/* src/vofn_pkg.sv */
package vofn_pkg;

    localparam int HEIGHT    = 7;
    localparam int MAX_WIDTH = 1024;

    localparam int HR    = (HEIGHT - 1) / 2;
    localparam int RW    = (HR > 1) ? HR : 1;
    localparam int WS    = 2 * RW + 1;
    localparam int LINES = WS;
    localparam int HS    = 2 * HR + 1;
    localparam int DEPTH = LINES * MAX_WIDTH;

    localparam int FULL      = 32768;
    localparam int ONE_SLOPE = 65536;

    localparam int FRAC_W = 16;
    localparam int FW_W   = 11;
    localparam int METH_W = 2;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = 16;
    localparam int OCOL_W = 10;
    localparam int OUT_W  = 17;
    localparam int SLOT_W = $clog2(LINES);
    localparam int IDX_W  = $clog2(WS);
    localparam int ADDR_W = $clog2(DEPTH);

    // magnitude of a sum, a gradient or a unit slope
    localparam int MAG_W  = $clog2(((HS > 4) ? HS : 4) * FULL + 1);
    localparam int ACC_W  = MAG_W + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int S_W    = MAG_W + 1;
    localparam int D_W    = S_W + 1;
    localparam int N_W    = MAG_W + 17;
    localparam int Q_W    = 16;
    localparam int QC_W   = $clog2(Q_W + 1);

    localparam logic [METH_W-1:0] METH_YOUNGS = 2'd0;
    localparam logic [METH_W-1:0] METH_HEIGHT = 2'd1;
    localparam logic [METH_W-1:0] METH_MYCS   = 2'd2;

    localparam logic REG_METHOD = 1'b0;
    localparam logic REG_WIDTH  = 1'b1;

    typedef struct packed {
        logic accept;
        logic rd;
        logic calc;
        logic pick;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic rd_last;
        logic div_busy;
        logic out_free;
    } t_stat;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] neg;
        neg = -x;
        return (x < 0) ? neg[MAG_W-1:0] : x[MAG_W-1:0];
    endfunction

endpackage

/* src/vofn_div.sv */
module vofn_div
    import vofn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [N_W-1:0]   i_num,
    input  logic [D_W-1:0]   i_den,
    output logic             o_busy,
    output logic [Q_W-1:0]   o_quot
);

    logic [D_W-1:0]  r_rem, n_rem;
    logic [D_W-1:0]  r_den;
    logic [Q_W-1:0]  r_low;
    logic [Q_W-1:0]  r_quot;
    logic [QC_W-1:0] r_cnt;
    logic            r_busy;
    logic [D_W:0]    trial;
    logic            ge;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial = {r_rem, r_low[Q_W-1]};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? D_W'(trial - {1'b0, r_den}) : trial[D_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= QC_W'(Q_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == QC_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= D_W'(i_num[N_W-1:Q_W]);
            r_low  <= i_num[Q_W-1:0];
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_low  <= {r_low[Q_W-2:0], 1'b0};
            r_quot <= {r_quot[Q_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

/* src/vofn_ctrl.sv */
module vofn_ctrl
    import vofn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_CALC,
        S_PICK,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_stat.emit) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (i_stat.rd_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: r_state <= S_CALC;
                S_CALC:  r_state <= S_PICK;
                S_PICK:  r_state <= S_DIV;
                S_DIV: begin
                    if (!i_stat.div_busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_in_ready     = (r_state == S_IDLE);
        o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd       = (r_state == S_READ);
        o_cmd.calc     = (r_state == S_CALC);
        o_cmd.pick     = (r_state == S_PICK);
        o_cmd.load_out = (r_state == S_DONE) && i_stat.out_free;
    end

endmodule

/* src/vofn_dp.sv */
module vofn_dp
    import vofn_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic [METH_W-1:0]        i_method,
    input  logic [FW_W-1:0]          i_frame_width,
    input  logic [FRAC_W-1:0]        i_fraction,
    input  logic                     i_frame_start,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [OUT_W-1:0]  o_normal_x,
    output logic signed [OUT_W-1:0]  o_normal_y,
    output logic [OCOL_W-1:0]        o_cell_col,
    output logic [ROW_W-1:0]         o_cell_row,
    output logic                     o_is_interface
);

    // line store
    logic [FRAC_W-1:0] mem [DEPTH];
    logic [FRAC_W-1:0] r_rdata;

    // raster counters
    logic [COL_W-1:0]  r_col, e_col;
    logic [ROW_W-1:0]  r_row, e_row;
    logic [SLOT_W-1:0] r_slot, e_slot;
    logic [31:0]       eff_w;
    logic [FRAC_W-1:0] f_sat;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [31:0]       rd_col;

    // current center and window sweep
    logic [COL_W-1:0]  r_cur_col;
    logic [ROW_W-1:0]  r_cur_row;
    logic [SLOT_W-1:0] r_rslot;
    logic [IDX_W-1:0]  r_rx, r_ry, r_tx, r_ty;
    logic              r_dv;

    // accumulators
    logic signed [ACC_W-1:0] r_sl, r_sr, r_su, r_sd, r_gx, r_gy;
    logic [FRAC_W-1:0]       r_ctr;
    logic signed [ACC_W-1:0] v1, v2, wx, wy;
    logic                    in_hr_x, in_hr_y, near_x, near_y;

    // slope stage
    logic signed [ACC_W-1:0] r_hx, r_hy;
    logic                    r_hor, r_den_zero;
    logic [MAG_W-1:0]        r_gnum;
    logic [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0] hx, hy;
    logic [MAG_W-1:0]        mhx, mhy, mgx, mgy;
    logic [PROD_W-1:0]       pa, pb;

    // pick stage
    logic signed [ACC_W-1:0] one, cx, cy, ax, ay;
    logic                    take_y, forced;
    logic [PROD_W-1:0]       lhs;
    logic [MAG_W-1:0]        ma, mb;
    logic [S_W-1:0]          s_sum;
    logic [N_W-1:0]          num;
    logic [D_W-1:0]          den;
    logic                    r_ax_pos, r_ax_neg, r_ay_pos, r_ay_neg, r_zero, r_forced;

    // divider and result
    logic                    div_busy;
    logic [Q_W-1:0]          quot;
    logic [OUT_W-1:0]        mx, my, nx, ny;
    logic [31:0]             ocol, orow;

    logic                    r_out_valid;

    always_comb begin
        e_col  = i_frame_start ? '0 : r_col;
        e_row  = i_frame_start ? '0 : r_row;
        e_slot = i_frame_start ? '0 : r_slot;
        eff_w  = 32'(i_frame_width);
        if (eff_w < 32'd3) begin
            eff_w = 32'd3;
        end
        if (eff_w > 32'(MAX_WIDTH)) begin
            eff_w = 32'(MAX_WIDTH);
        end
        f_sat   = (i_fraction > FRAC_W'(FULL)) ? FRAC_W'(FULL) : i_fraction;
        wr_addr = ADDR_W'(32'(e_slot) * 32'(MAX_WIDTH) + 32'(e_col));
        rd_col  = 32'(r_cur_col) - 32'(2 * RW) + 32'(r_rx);
        rd_addr = ADDR_W'(32'(r_rslot) * 32'(MAX_WIDTH) + rd_col);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            mem[wr_addr] <= f_sat;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (i_cmd.accept) begin
            if (32'(e_col) + 32'd1 >= eff_w) begin
                r_col  <= '0;
                r_row  <= (e_row == '1) ? e_row : e_row + 1'b1;
                r_slot <= (e_slot == SLOT_W'(LINES - 1)) ? '0 : e_slot + 1'b1;
            end else begin
                r_col  <= e_col + 1'b1;
                r_row  <= e_row;
                r_slot <= e_slot;
            end
        end
    end

    // window sweep, oldest row first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else begin
            r_dv <= i_cmd.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur_col <= e_col;
            r_cur_row <= e_row;
            r_rslot   <= (e_slot == SLOT_W'(LINES - 1)) ? '0 : e_slot + 1'b1;
            r_rx      <= '0;
            r_ry      <= '0;
        end else if (i_cmd.rd) begin
            if (r_rx == IDX_W'(WS - 1)) begin
                r_rx    <= '0;
                r_ry    <= r_ry + 1'b1;
                r_rslot <= (r_rslot == SLOT_W'(LINES - 1)) ? '0 : r_rslot + 1'b1;
            end else begin
                r_rx <= r_rx + 1'b1;
            end
        end
        if (i_cmd.rd) begin
            r_tx <= r_rx;
            r_ty <= r_ry;
        end
    end

    // per-cell contributions
    always_comb begin
        v1      = $signed({{(ACC_W - FRAC_W){1'b0}}, r_rdata});
        v2      = v1 <<< 1;
        in_hr_x = (r_tx >= IDX_W'(RW - HR)) && (r_tx <= IDX_W'(RW + HR));
        in_hr_y = (r_ty >= IDX_W'(RW - HR)) && (r_ty <= IDX_W'(RW + HR));
        near_x  = (r_tx >= IDX_W'(RW - 1)) && (r_tx <= IDX_W'(RW + 1));
        near_y  = (r_ty >= IDX_W'(RW - 1)) && (r_ty <= IDX_W'(RW + 1));
        wy      = near_y ? ((r_ty == IDX_W'(RW)) ? v2 : v1) : '0;
        wx      = near_x ? ((r_tx == IDX_W'(RW)) ? v2 : v1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sl <= '0;
            r_sr <= '0;
            r_su <= '0;
            r_sd <= '0;
            r_gx <= '0;
            r_gy <= '0;
        end else if (r_dv) begin
            if (r_tx == IDX_W'(RW - 1)) begin
                r_gx <= r_gx + wy;
                if (in_hr_y) begin
                    r_sl <= r_sl + v1;
                end
            end
            if (r_tx == IDX_W'(RW + 1)) begin
                r_gx <= r_gx - wy;
                if (in_hr_y) begin
                    r_sr <= r_sr + v1;
                end
            end
            if (r_ty == IDX_W'(RW - 1)) begin
                r_gy <= r_gy + wx;
                if (in_hr_x) begin
                    r_su <= r_su + v1;
                end
            end
            if (r_ty == IDX_W'(RW + 1)) begin
                r_gy <= r_gy - wx;
                if (in_hr_x) begin
                    r_sd <= r_sd + v1;
                end
            end
            if (r_tx == IDX_W'(RW) && r_ty == IDX_W'(RW)) begin
                r_ctr <= r_rdata;
            end
        end
    end

    // height slopes and the cross product for the mixed choice
    always_comb begin
        hx  = r_sl - r_sr;
        hy  = r_su - r_sd;
        mhx = mag_of(hx);
        mhy = mag_of(hy);
        mgx = mag_of(r_gx);
        mgy = mag_of(r_gy);
        pa  = PROD_W'(mhx < mhy ? mhx : mhy);
        pb  = PROD_W'(mhx < mhy ? mgy : mgx);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_hx       <= hx;
            r_hy       <= hy;
            r_hor      <= (mhx < mhy);
            r_gnum     <= (mhx < mhy) ? mgx : mgy;
            r_den_zero <= (mhx < mhy) ? (r_gy == '0) : (r_gx == '0);
            r_prod     <= pa * pb;
        end
    end

    // method select and divider operands
    always_comb begin
        one = ACC_W'(ONE_SLOPE);
        if (r_hor) begin
            cx = r_hx;
            cy = (r_hy > 0) ? one : ((r_hy < 0) ? -one : '0);
        end else begin
            cx = (r_hx > 0) ? one : ((r_hx < 0) ? -one : '0);
            cy = r_hy;
        end
        lhs    = PROD_W'({r_gnum, 16'h0});
        take_y = (i_method != METH_HEIGHT) && (r_den_zero || (lhs > r_prod));
        forced = (i_method != METH_YOUNGS) &&
                 ((r_ctr == '0) || (r_ctr == FRAC_W'(FULL)));
        if (i_method == METH_YOUNGS) begin
            ax = r_gx;
            ay = r_gy;
        end else if (forced) begin
            ax = '0;
            ay = '0;
        end else begin
            ax = take_y ? r_gx : cx;
            ay = take_y ? r_gy : cy;
        end
        ma    = mag_of(ax);
        mb    = mag_of(ay);
        s_sum = S_W'(ma) + S_W'(mb);
        num   = N_W'({ma, 16'h0}) + N_W'(s_sum);
        den   = {s_sum, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_ax_pos <= (ax > 0);
            r_ax_neg <= (ax < 0);
            r_ay_pos <= (ay > 0);
            r_ay_neg <= (ay < 0);
            r_zero   <= (s_sum == '0);
            r_forced <= forced;
        end
    end

    vofn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.pick),
        .i_num   (num),
        .i_den   (den),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    // signs and output register
    always_comb begin
        mx   = OUT_W'(quot);
        my   = OUT_W'(FULL) - mx;
        nx   = r_zero ? '0 : (r_ax_pos ? mx : (r_ax_neg ? -mx : '0));
        ny   = r_zero ? '0 : (r_ay_pos ? my : (r_ay_neg ? -my : '0));
        ocol = 32'(r_cur_col) - 32'(RW);
        orow = 32'(r_cur_row) - 32'(RW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_normal_x     <= $signed(nx);
            o_normal_y     <= $signed(ny);
            o_cell_col     <= ocol[OCOL_W-1:0];
            o_cell_row     <= orow[ROW_W-1:0];
            o_is_interface <= !r_forced;
        end
    end

    always_comb begin
        o_stat.emit     = (32'(e_row) >= 32'(2 * RW)) && (32'(e_col) >= 32'(2 * RW));
        o_stat.rd_last  = (r_rx == IDX_W'(WS - 1)) && (r_ry == IDX_W'(WS - 1));
        o_stat.div_busy = div_busy;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;

endmodule

/* src/vof_interface_normal.sv */
// channel   | handshake                  | payload
// ----------+----------------------------+----------------------------------------------
// in        | i_in_valid / o_in_ready    | i_fraction, i_frame_start
// out       | o_out_valid / i_out_ready  | o_normal_x, o_normal_y, o_cell_col,
//           |                            | o_cell_row, o_is_interface
// config    | psel, penable, pwrite      | paddr, pwdata, prdata (pready tied high)
//
// a cell that yields no normal (edge of the grid) is taken while the block stays idle and ready
// an interior cell steps through accept, a read of each cell of the 7x7 window,
// drain, slope calc, method pick, the divider for 16 quotient bits, then the output load
// the finished normal sits in an output register, so the next request is taken
// while it waits; if the register is still full the load stalls until it drains
// synchronous active-low reset clears counters and control, not the line store
module vof_interface_normal
    import vofn_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input requests
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [FRAC_W-1:0]        i_fraction,
    input  logic                     i_frame_start,
    // results
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [OUT_W-1:0]  o_normal_x,
    output logic signed [OUT_W-1:0]  o_normal_y,
    output logic [OCOL_W-1:0]        o_cell_col,
    output logic [ROW_W-1:0]         o_cell_row,
    output logic                     o_is_interface,
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [METH_W-1:0] r_method;
    logic [FW_W-1:0]   r_frame_width;
    logic              wr_en;
    t_cmd              cmd;
    t_stat             stat;

    // register file: method at 0x0, frame width at 0x4
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method      <= METH_MYCS;
            r_frame_width <= FW_W'(MAX_WIDTH);
        end else if (wr_en) begin
            if (paddr[2] == REG_METHOD) begin
                r_method <= pwdata[METH_W-1:0];
            end else begin
                r_frame_width <= pwdata[FW_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_WIDTH) begin
            prdata = 32'(r_frame_width);
        end else begin
            prdata = 32'(r_method);
        end
    end

    // sequencer
    vofn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // line store, window sums, slope choice, divider and output register
    vofn_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_method       (r_method),
        .i_frame_width  (r_frame_width),
        .i_fraction     (i_fraction),
        .i_frame_start  (i_frame_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_cell_col     (o_cell_col),
        .o_cell_row     (o_cell_row),
        .o_is_interface (o_is_interface)
    );

endmodule

/* tb/vof_interface_normal_test.sv */
module vof_interface_normal_test;
    import vofn_pkg::*;

    // cell request as queued for the driver
    typedef struct {
        logic [FRAC_W-1:0] frac;
        logic              first;
    } t_cell;

    // one interface normal as the block should report it
    typedef struct {
        logic signed [OUT_W-1:0] nx;
        logic signed [OUT_W-1:0] ny;
        logic [OCOL_W-1:0]       col;
        logic [ROW_W-1:0]        row;
        logic                    is_if;
    } t_normal;

    localparam longint CYCLE_LIMIT = 3000000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [FRAC_W-1:0]       i_fraction;
    logic                    i_frame_start;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [OUT_W-1:0] o_normal_x;
    logic signed [OUT_W-1:0] o_normal_y;
    logic [OCOL_W-1:0]       o_cell_col;
    logic [ROW_W-1:0]        o_cell_row;
    logic                    o_is_interface;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [2:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    vof_interface_normal DUT (.*);

    // pending cells, expected normals, bookkeeping
    t_cell   cell_queue[$];
    t_normal normal_queue[$];
    int      errors;
    longint  cycles;
    int      cells_sent;
    int      normals_seen;
    int      forced_seen;
    bit      calm;          // no idling in the closing part of the run
    int      in_gap;
    int      out_stall;

    // predictor state: own copy of line store, counters and registers
    logic [FRAC_W-1:0] lines_mem[LINES][MAX_WIDTH];
    int unsigned       p_col;
    int unsigned       p_row;
    int unsigned       p_slot;
    int unsigned       p_method;
    int unsigned       p_width;

    function automatic longint absval(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint signof(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // advance the predictor by one cell; returns 1 when a normal is due
    function automatic bit predict_normal(input t_cell c, output t_normal n);
        longint      w[WS][WS];
        longint      gx, gy, hx, hy, ax, ay, sl, sr, su, sd, ctr;
        longint      ma, mb, s, mx, cx, cy;
        int unsigned f, width, sl_idx;
        bit          hit, forced, hor, take_y;
        f   = c.frac;
        hit = 0;
        if (f > FULL) f = FULL;
        if (c.first) begin
            p_col  = 0;
            p_row  = 0;
            p_slot = 0;
        end
        width = p_width;
        if (width < 3) width = 3;
        if (width > MAX_WIDTH) width = MAX_WIDTH;
        lines_mem[p_slot][p_col] = f[FRAC_W-1:0];

        if (p_row >= 2 * RW && p_col >= 2 * RW) begin
            for (int dy = 0; dy < WS; dy++) begin
                sl_idx = (p_slot + LINES - (WS - 1 - dy)) % LINES;
                for (int dx = 0; dx < WS; dx++)
                    w[dy][dx] = lines_mem[sl_idx][p_col - 2 * RW + dx];
            end
            // window indexed [y+RW][x+RW]
            ctr = w[RW][RW];
            gx = (w[RW+1][RW-1] + 2 * w[RW][RW-1] + w[RW-1][RW-1])
               - (w[RW+1][RW+1] + 2 * w[RW][RW+1] + w[RW-1][RW+1]);
            gy = (w[RW-1][RW+1] + 2 * w[RW-1][RW] + w[RW-1][RW-1])
               - (w[RW+1][RW+1] + 2 * w[RW+1][RW] + w[RW+1][RW-1]);
            sl = 0; sr = 0; su = 0; sd = 0;
            for (int k = -HR; k <= HR; k++) begin
                sl += w[RW+k][RW-1];
                sr += w[RW+k][RW+1];
                su += w[RW-1][RW+k];
                sd += w[RW+1][RW+k];
            end
            hx = sl - sr;
            hy = su - sd;
            forced = 0;
            if (p_method == METH_YOUNGS) begin
                ax = gx;
                ay = gy;
            end else if (ctr == 0 || ctr == FULL) begin
                // full or empty center: normal forced to zero
                forced = 1;
                ax = 0;
                ay = 0;
            end else begin
                hor = absval(hx) < absval(hy);
                cx  = hor ? hx : signof(hx) * ONE_SLOPE;
                cy  = hor ? signof(hy) * ONE_SLOPE : hy;
                take_y = 0;
                if (p_method != METH_HEIGHT) begin
                    // zero youngs denominator means infinite ratio
                    if (hor)
                        take_y = (gy == 0) ||
                                 absval(gx) * ONE_SLOPE > absval(hx) * absval(gy);
                    else
                        take_y = (gx == 0) ||
                                 absval(gy) * ONE_SLOPE > absval(hy) * absval(gx);
                end
                ax = take_y ? gx : cx;
                ay = take_y ? gy : cy;
            end
            ma = absval(ax);
            mb = absval(ay);
            s  = ma + mb;
            if (s == 0) begin
                n.nx = '0;
                n.ny = '0;
            end else begin
                mx   = (ma * 65536 + s) / (2 * s);
                n.nx = OUT_W'(signof(ax) * mx);
                n.ny = OUT_W'(signof(ay) * (FULL - mx));
            end
            n.col   = OCOL_W'(p_col - RW);
            n.row   = ROW_W'(p_row - RW);
            n.is_if = !forced;
            hit = 1;
        end

        if (p_col + 1 >= width) begin
            p_col = 0;
            if (p_row < 65535) p_row++;
            p_slot = (p_slot + 1) % LINES;
        end else begin
            p_col++;
        end
        return hit;
    endfunction

    // clock and reset
    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // driver: presents queued cells, idles in random bursts
    always @(posedge i_clk) begin
        t_normal n;
        if (!i_rst_n) begin
            i_in_valid    <= 1'b0;
            i_fraction    <= '0;
            i_frame_start <= 1'b0;
            in_gap        <= 0;
        end else begin
            // accepted request feeds the predictor
            if (i_in_valid && o_in_ready) begin
                cells_sent++;
                if (predict_normal('{i_fraction, i_frame_start}, n))
                    normal_queue.push_back(n);
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap     <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    in_gap     <= $urandom_range(0, 10);
                    i_in_valid <= 1'b0;
                end else if (cell_queue.size() > 0) begin
                    t_cell c;
                    c = cell_queue.pop_front();
                    i_in_valid    <= 1'b1;
                    i_fraction    <= c.frac;
                    i_frame_start <= c.first;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random backpressure, field checks against the oldest expectation
    always @(posedge i_clk) begin
        t_normal e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall   <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (normal_queue.size() == 0) begin
                    $error("unexpected normal at col %0d row %0d", o_cell_col, o_cell_row);
                    errors++;
                end else begin
                    e = normal_queue.pop_front();
                    normals_seen++;
                    if (!e.is_if) forced_seen++;
                    if (o_normal_x !== e.nx) begin
                        $error("normal_x exp %0d got %0d", e.nx, o_normal_x);
                        errors++;
                    end
                    if (o_normal_y !== e.ny) begin
                        $error("normal_y exp %0d got %0d", e.ny, o_normal_y);
                        errors++;
                    end
                    if (o_cell_col !== e.col) begin
                        $error("cell_col exp %0d got %0d", e.col, o_cell_col);
                        errors++;
                    end
                    if (o_cell_row !== e.row) begin
                        $error("cell_row exp %0d got %0d", e.row, o_cell_row);
                        errors++;
                    end
                    if (o_is_interface !== e.is_if) begin
                        $error("is_interface exp %0d got %0d", e.is_if, o_is_interface);
                        errors++;
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall   <= out_stall - 1;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_stall   <= $urandom_range(0, 10);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // register write: setup then access cycle
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'(4 * REG_METHOD)) p_method = data & 3;
        else                           p_width  = data & 32'h7FF;
    endtask

    // hold off until the block has drained every request and result
    task automatic wait_drained();
        while (cell_queue.size() > 0 || i_in_valid || normal_queue.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // one grid: new config, then cells starting with a frame start
    task automatic run_grid(input int meth, input int wreg, input int ncells);
        int     weff, col, row, kind, a, b, base;
        longint v;
        t_cell  c;
        wait_drained();
        reg_write(3'(4 * REG_METHOD), 32'(meth));
        reg_write(3'(4 * REG_WIDTH), 32'(wreg));
        weff = (wreg < 3) ? 3 : ((wreg > MAX_WIDTH) ? MAX_WIDTH : wreg);
        // random plane slopes give realistic interfaces
        a    = $urandom_range(0, 16000) - 8000;
        b    = $urandom_range(0, 16000) - 8000;
        base = $urandom_range(0, 32768);
        for (int k = 0; k < ncells; k++) begin
            col  = k % weff;
            row  = k / weff;
            kind = $urandom_range(0, 9);
            v    = base + longint'(a) * (col - weff / 2) + longint'(b) * (row - 5);
            if (v < 0) v = 0;
            if (v > FULL) v = FULL;
            if (kind < 6)       c.frac = 16'(v);
            else if (kind == 6) c.frac = 16'd0;
            else if (kind == 7) c.frac = 16'(FULL);
            else if (kind == 8) c.frac = 16'($urandom_range(0, FULL));
            else                c.frac = 16'($urandom);
            c.first = (k == 0);
            cell_queue.push_back(c);
        end
    endtask

    initial begin
        t_cell c;
        errors        = 0;
        cycles        = 0;
        cells_sent    = 0;
        normals_seen  = 0;
        forced_seen   = 0;
        calm          = 0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        p_col         = 0;
        p_row         = 0;
        p_slot        = 0;
        p_method      = METH_MYCS;
        p_width       = MAX_WIDTH;
        foreach (lines_mem[s, x]) lines_mem[s][x] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: width 8, rows full above, one half full, empty below, extreme fractions,
        // a frame restart mid-grid that carries the rest of the rows as a new grid
        wait_drained();
        reg_write(3'(4 * REG_WIDTH), 32'd8);
        for (int k = 0; k < 96; k++) begin
            case (k % 8)
                0:       c.frac = 16'hFFFF;          // above full, saturates
                1:       c.frac = 16'(FULL + 1);
                2:       c.frac = 16'd1;
                default: c.frac = (k / 8 < 3) ? 16'(FULL) :
                                  ((k / 8 == 3) ? 16'd16384 : 16'd0);
            endcase
            c.first = (k == 0) || (k == 16);
            cell_queue.push_back(c);
        end

        // random grids over all methods, clamped widths and the width extremes
        run_grid(METH_YOUNGS, 8, 150);
        run_grid(METH_HEIGHT, 10, 150);
        run_grid(3, 7, 100);                 // method three acts as mycs
        run_grid(METH_MYCS, 0, 30);          // clamps to 3: too narrow, no normals
        run_grid(METH_YOUNGS, 2047, 40);     // clamps to the full line length
        run_grid(METH_HEIGHT, 3, 20);
        run_grid(METH_MYCS, 12, 200);
        run_grid(METH_YOUNGS, 9, 120);

        // closing grid without idling on either side
        wait_drained();
        calm = 1;
        run_grid(METH_MYCS, 8, 150);

        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("covered %0d cells, %0d normals (%0d forced to zero), methods 0-3,",
                 cells_sent, normals_seen, forced_seen);
        $display("widths 0 to 2047 with clamping and saturating fractions");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
